// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the branch predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Types and constants shared by the gshare branch predictor modules.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_COUNTER_BITS  = 2;
    localparam int DEF_THREADS       = 4;

    localparam int PC_W       = 48;
    localparam int SNAP_W     = 12;
    localparam int THREAD_W   = 2;
    localparam int PC_SHIFT_W = 2;

    localparam logic [PC_SHIFT_W-1:0] PC_SHIFT_RST = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP      = 2'd0,
        OP_HIST_UPDATE = 2'd1,
        OP_SQUASH      = 2'd2,
        OP_TRAIN       = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 opcode;
        logic [THREAD_W-1:0] thread;
        logic [PC_W-1:0]     pc;
        logic                taken;
        logic                uncond;
        logic                squashed;
        logic [SNAP_W-1:0]   snapshot_in;
    } req_t;

    typedef struct packed {
        logic              predict_taken;
        logic [SNAP_W-1:0] snapshot_out;
    } rsp_t;

endpackage

// ===== rtl/gshare_branch_predictor_unit.sv =====
// Throughput: one transaction per cycle unless the table clear or a response stall
// holds the pipeline, set by the single read and write port of the counter memory,
// with forwarding of the previous write-back.
// Reset: histories and pc_shift (to 2) reset at once; the counter memory is then
// swept to zero, entry by entry, while req_stall is held high.
// ----------------------------------------------------------------------------
// gshare_branch_predictor_unit
// Gshare predictor top level: request decode, history update, counter
// read-modify-write pipeline and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gshare_branch_predictor_unit #(
    parameter int TABLE_ENTRIES = gbp_pkg::DEF_TABLE_ENTRIES,
    parameter int COUNTER_BITS  = gbp_pkg::DEF_COUNTER_BITS,
    parameter int THREADS       = gbp_pkg::DEF_THREADS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  gbp_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output gbp_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbp_pkg::PC_SHIFT_W-1:0] cfg_data
);

    localparam int HB     = $clog2(TABLE_ENTRIES);
    localparam int WIDE_W = (HB > gbp_pkg::SNAP_W) ? HB : gbp_pkg::SNAP_W;

    logic [gbp_pkg::PC_SHIFT_W-1:0] pc_shift_reg;
    logic [gbp_pkg::PC_SHIFT_W-1:0] pc_shift_next;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    gbp_pkg::op_t                   s1_op_reg;
    logic                           s1_taken_reg;
    logic                           s1_squashed_reg;
    logic [HB-1:0]                  s1_idx_reg;
    logic [gbp_pkg::SNAP_W-1:0]     s1_snap_reg;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    gbp_pkg::rsp_t                  rsp_reg;
    gbp_pkg::rsp_t                  rsp_next;

    logic                           clearing;
    logic                           accept;
    logic                           s1_adv;
    logic [HB-1:0]                  cur_hist;
    logic [HB-1:0]                  snap_h;
    logic [WIDE_W-1:0]              snap_wide;
    logic [WIDE_W-1:0]              hist_wide;
    logic [gbp_pkg::PC_W-1:0]       pc_sh;
    logic [HB-1:0]                  idx;
    logic                           hist_we;
    logic [HB-1:0]                  hist_wdata;
    logic [COUNTER_BITS-1:0]        ctr_rd;
    logic [COUNTER_BITS-1:0]        ctr_new;
    logic                           ctr_we;

    gbp_history #(
        .THREADS   (THREADS),
        .HIST_BITS (HB)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_thread (req.thread),
        .rd_hist   (cur_hist),
        .wr_en     (hist_we),
        .wr_thread (req.thread),
        .wr_hist   (hist_wdata)
    );

    gbp_counter_table #(
        .ENTRIES      (TABLE_ENTRIES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counter_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .rd_en    (accept),
        .rd_addr  (idx),
        .rd_data  (ctr_rd),
        .wr_en    (ctr_we),
        .wr_addr  (s1_idx_reg),
        .wr_data  (ctr_new)
    );

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = clearing || (s1_valid_reg && !s1_adv);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        pc_shift_next = pc_shift_reg;
        if (cfg_valid && cfg_ready)
        begin
            pc_shift_next = cfg_data;
        end

        snap_wide = WIDE_W'(req.snapshot_in);
        snap_h    = snap_wide[HB-1:0];
        hist_wide = WIDE_W'(cur_hist);
        pc_sh     = req.pc >> pc_shift_reg;

        if (req.opcode == gbp_pkg::OP_TRAIN)
        begin
            idx = pc_sh[HB-1:0] ^ snap_h;
        end
        else
        begin
            idx = pc_sh[HB-1:0] ^ cur_hist;
        end

        hist_we    = 1'b0;
        hist_wdata = cur_hist;
        case (req.opcode)
            gbp_pkg::OP_HIST_UPDATE:
            begin
                hist_we    = accept;
                hist_wdata = {cur_hist[HB-2:0], req.taken};
            end
            gbp_pkg::OP_SQUASH:
            begin
                hist_we    = accept;
                hist_wdata = snap_h;
            end
            gbp_pkg::OP_TRAIN:
            begin
                hist_we    = accept && req.squashed;
                hist_wdata = {snap_h[HB-2:0], req.taken};
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase

        s1_valid_next = accept || (s1_valid_reg && !s1_adv);

        ctr_new = ctr_rd;
        if (s1_taken_reg)
        begin
            if (ctr_rd != {COUNTER_BITS{1'b1}})
            begin
                ctr_new = ctr_rd + COUNTER_BITS'(1);
            end
        end
        else if (ctr_rd != '0)
        begin
            ctr_new = ctr_rd - COUNTER_BITS'(1);
        end
        ctr_we = s1_adv && s1_op_reg == gbp_pkg::OP_TRAIN && !s1_squashed_reg;

        rsp_valid_next = s1_adv || (rsp_valid_reg && rsp_stall);
        rsp_next       = rsp_reg;
        if (s1_adv)
        begin
            rsp_next.predict_taken = (s1_op_reg == gbp_pkg::OP_LOOKUP) && ctr_rd[COUNTER_BITS-1];
            rsp_next.snapshot_out  = s1_snap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_shift_reg  <= gbp_pkg::PC_SHIFT_RST;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_shift_reg  <= pc_shift_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= req.opcode;
            s1_taken_reg    <= req.taken;
            s1_squashed_reg <= req.squashed;
            s1_idx_reg      <= idx;
            s1_snap_reg     <= hist_wide[gbp_pkg::SNAP_W-1:0];
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMPLY(a_no_accept_clearing, clk, rst_n, accept, !clearing,
                  "transaction accepted during table clear")
    `ASSERT_IMPLY(a_wb_needs_s1, clk, rst_n, ctr_we, s1_valid_reg,
                  "counter write-back without a transaction in flight")
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_reg,
                 "accepted transaction lost before read stage")
    `ASSERT_IMPLY(a_s1_blocked_stalls, clk, rst_n, s1_valid_reg && !s1_adv, req_stall,
                  "request taken while read stage is blocked")

endmodule

// ===== rtl/gbp_history.sv =====
// ----------------------------------------------------------------------------
// gbp_history
// Per-thread global history registers with one read and one write port.
// ----------------------------------------------------------------------------
module gbp_history #(
    parameter int THREADS   = gbp_pkg::DEF_THREADS,
    parameter int HIST_BITS = $clog2(gbp_pkg::DEF_TABLE_ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gbp_pkg::THREAD_W-1:0]  rd_thread,
    output logic [HIST_BITS-1:0]          rd_hist,
    input  logic                          wr_en,
    input  logic [gbp_pkg::THREAD_W-1:0]  wr_thread,
    input  logic [HIST_BITS-1:0]          wr_hist
);

    logic [HIST_BITS-1:0] hist_reg  [THREADS];
    logic [HIST_BITS-1:0] hist_next [THREADS];

    // A thread number without a register reads as zero and drops writes.
    always_comb
    begin
        rd_hist = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            hist_next[i] = hist_reg[i];
            if (int'(rd_thread) == i)
            begin
                rd_hist = hist_reg[i];
            end
            if (wr_en && int'(wr_thread) == i)
            begin
                hist_next[i] = wr_hist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

endmodule

// ===== rtl/gbp_counter_table.sv =====
// ----------------------------------------------------------------------------
// gbp_counter_table
// Saturating counter memory with a clearing sweep after reset and forwarding
// of the most recent write into the registered read data.
// ----------------------------------------------------------------------------
module gbp_counter_table #(
    parameter int ENTRIES      = gbp_pkg::DEF_TABLE_ENTRIES,
    parameter int COUNTER_BITS = gbp_pkg::DEF_COUNTER_BITS,
    localparam int AW          = $clog2(ENTRIES)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    clearing,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [COUNTER_BITS-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [COUNTER_BITS-1:0] wr_data
);

    logic [COUNTER_BITS-1:0] mem [ENTRIES];

    logic                    clear_reg;
    logic                    clear_next;
    logic [AW-1:0]           clr_idx_reg;
    logic [AW-1:0]           clr_idx_next;
    logic                    lw_valid_reg;
    logic                    lw_valid_next;
    logic [AW-1:0]           lw_addr_reg;
    logic [COUNTER_BITS-1:0] lw_data_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [COUNTER_BITS-1:0] rd_data_reg;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;

    always_comb
    begin
        clear_next    = clear_reg;
        clr_idx_next  = clr_idx_reg;
        lw_valid_next = lw_valid_reg | wr_en;
        mem_we        = wr_en;
        mem_waddr     = wr_addr;
        mem_wdata     = wr_data;
        if (clear_reg)
        begin
            mem_we       = 1'b1;
            mem_waddr    = clr_idx_reg;
            mem_wdata    = '0;
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == {AW{1'b1}})
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_idx_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_idx_reg  <= clr_idx_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    // The last write is always the newest value of its entry.
    assign rd_data  = (lw_valid_reg && lw_addr_reg == rd_addr_reg) ? lw_data_reg : rd_data_reg;
    assign clearing = clear_reg;

endmodule

// ===== dv/gshare_branch_predictor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor_unit_tb
// Self-checking testbench for the gshare branch predictor. A bursty driver
// feeds lookup, history update, squash and train transactions from a queue.
// A predictor of the history registers and the counter table computes each
// response, and a monitor compares every response against it while the
// response side stalls. Runs under every pc_shift setting.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_unit_tb;

    localparam int TABLE_ENTRIES = gbp_pkg::DEF_TABLE_ENTRIES;
    localparam int COUNTER_BITS  = gbp_pkg::DEF_COUNTER_BITS;
    localparam int THREADS       = gbp_pkg::DEF_THREADS;
    localparam int HIST_W        = $clog2(TABLE_ENTRIES);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    gbp_pkg::req_t                  req       = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    gbp_pkg::rsp_t                  rsp;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gbp_pkg::PC_SHIFT_W-1:0] cfg_data  = '0;

    logic [HIST_W-1:0]              hist_q [THREADS];
    logic [COUNTER_BITS-1:0]        ctr_q  [TABLE_ENTRIES];
    logic [gbp_pkg::PC_SHIFT_W-1:0] shift_q;

    gbp_pkg::req_t op_queue [$];
    gbp_pkg::rsp_t rsp_queue [$];
    gbp_pkg::rsp_t want_rsp;

    int mismatches    = 0;
    int rsps_checked  = 0;
    int taken_preds   = 0;
    int op_count [4]  = '{default: 0};
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_cycle   = 0;
    int stall_mode    = 0;

    logic [gbp_pkg::PC_W-1:0]   pc_pool   [8];
    logic                       pc_bias   [8];
    logic [gbp_pkg::SNAP_W-1:0] snap_pool [4];

    gshare_branch_predictor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Timed out with %0d responses outstanding.", rsp_queue.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic gbp_pkg::rsp_t gshare_step(gbp_pkg::req_t r);
        logic [HIST_W-1:0]        h;
        logic [HIST_W-1:0]        idx;
        logic [gbp_pkg::PC_W-1:0] pcs;
        gbp_pkg::rsp_t            o;
        h   = hist_q[r.thread];
        pcs = r.pc >> shift_q;
        o   = '0;
        o.snapshot_out = gbp_pkg::SNAP_W'(h);
        op_count[r.opcode]++;
        case (r.opcode)
            gbp_pkg::OP_LOOKUP:
            begin
                idx = pcs[HIST_W-1:0] ^ h;
                o.predict_taken = ctr_q[idx][COUNTER_BITS-1];
                if (o.predict_taken)
                    taken_preds++;
            end
            gbp_pkg::OP_HIST_UPDATE:
                hist_q[r.thread] = {h[HIST_W-2:0], r.taken};
            gbp_pkg::OP_SQUASH:
                hist_q[r.thread] = r.snapshot_in[HIST_W-1:0];
            gbp_pkg::OP_TRAIN:
            begin
                if (r.squashed)
                    hist_q[r.thread] = {r.snapshot_in[HIST_W-2:0], r.taken};
                else
                begin
                    idx = pcs[HIST_W-1:0] ^ r.snapshot_in[HIST_W-1:0];
                    if (r.taken && ctr_q[idx] != CTR_MAX)
                        ctr_q[idx] = ctr_q[idx] + 1'b1;
                    else if (!r.taken && ctr_q[idx] != '0)
                        ctr_q[idx] = ctr_q[idx] - 1'b1;
                end
            end
            default:
                o.predict_taken = 1'b0;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
                rsp_queue.push_back(gshare_step(req));
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (op_queue.size() != 0)
            begin
                req       <= op_queue.pop_front();
                req_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("Response with no transaction outstanding: %p", rsp);
                    mismatches++;
                end
                else
                begin
                    want_rsp = rsp_queue.pop_front();
                    rsps_checked++;
                    if (rsp.predict_taken !== want_rsp.predict_taken)
                    begin
                        $error("predict_taken: expected %0d, got %0d",
                               want_rsp.predict_taken, rsp.predict_taken);
                        mismatches++;
                    end
                    if (rsp.snapshot_out !== want_rsp.snapshot_out)
                    begin
                        $error("snapshot_out: expected 0x%03h, got 0x%03h",
                               want_rsp.snapshot_out, rsp.snapshot_out);
                        mismatches++;
                    end
                end
            end
            stall_cycle++;
            if (stall_cycle % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= (stall_cycle % 3 == 0);
                default: rsp_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    function automatic gbp_pkg::req_t branch_op(gbp_pkg::op_t op, int thr,
                                                logic [gbp_pkg::PC_W-1:0] pc, logic taken,
                                                logic uncond, logic squashed,
                                                logic [gbp_pkg::SNAP_W-1:0] snap);
        gbp_pkg::req_t r;
        r.opcode      = op;
        r.thread      = thr[gbp_pkg::THREAD_W-1:0];
        r.pc          = pc;
        r.taken       = taken;
        r.uncond      = uncond;
        r.squashed    = squashed;
        r.snapshot_in = snap;
        return r;
    endfunction

    function automatic logic [gbp_pkg::PC_W-1:0] rand_pc();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[gbp_pkg::PC_W-1:0];
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [gbp_pkg::SNAP_W-1:0] rand_snap();
        logic [31:0] w;
        w = $urandom;
        return w[gbp_pkg::SNAP_W-1:0];
    endfunction

    // Most traffic is branch episodes on a small set of addresses and histories,
    // so counters saturate and lookups see trained entries.
    task automatic queue_random_ops(int n);
        int                         added;
        int                         k;
        int                         t;
        logic                       tk;
        logic [gbp_pkg::SNAP_W-1:0] s;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                op_queue.push_back(branch_op(gbp_pkg::op_t'($urandom_range(0, 3)),
                                             $urandom_range(0, THREADS - 1), rand_pc(),
                                             rand_bit(), rand_bit(), rand_bit(),
                                             rand_snap()));
                added += 1;
            end
            else
            begin
                k  = $urandom_range(0, 7);
                t  = $urandom_range(0, THREADS - 1);
                s  = snap_pool[$urandom_range(0, 3)];
                tk = ($urandom_range(0, 9) < 8) ? pc_bias[k] : !pc_bias[k];
                op_queue.push_back(branch_op(gbp_pkg::OP_SQUASH, t, rand_pc(), rand_bit(),
                                             rand_bit(), rand_bit(), s));
                op_queue.push_back(branch_op(gbp_pkg::OP_LOOKUP, t, pc_pool[k], rand_bit(),
                                             rand_bit(), rand_bit(), rand_snap()));
                op_queue.push_back(branch_op(gbp_pkg::OP_HIST_UPDATE, t, pc_pool[k], tk,
                                             rand_bit(), rand_bit(), rand_snap()));
                op_queue.push_back(branch_op(gbp_pkg::OP_TRAIN, t, pc_pool[k], tk, rand_bit(),
                                             ($urandom_range(0, 7) == 0), s));
                added += 4;
            end
        end
    endtask

    task automatic wait_drained();
        while (op_queue.size() != 0 || req_valid || rsp_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pc_shift(logic [gbp_pkg::PC_SHIFT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shift_q = v;
    endtask

    initial
    begin
        logic [gbp_pkg::PC_W-1:0]       hot_pc;
        logic [gbp_pkg::PC_W-1:0]       ones_pc;
        logic [gbp_pkg::PC_SHIFT_W-1:0] shifts [3];

        shift_q = gbp_pkg::PC_SHIFT_RST;
        foreach (hist_q[i])
            hist_q[i] = '0;
        foreach (ctr_q[i])
            ctr_q[i] = '0;
        foreach (pc_pool[i])
        begin
            pc_pool[i] = rand_pc();
            pc_bias[i] = (i % 2 == 0);
        end
        snap_pool[0] = '0;
        snap_pool[1] = '1;
        snap_pool[2] = rand_snap();
        snap_pool[3] = rand_snap();
        hot_pc  = 48'h8000_0000_0ABC;
        ones_pc = '1;

        op_queue.push_back(branch_op(gbp_pkg::OP_LOOKUP, 0, '0, 1'b0, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_LOOKUP, 3, ones_pc, 1'b1, 1'b1, 1'b1, '1));
        op_queue.push_back(branch_op(gbp_pkg::OP_HIST_UPDATE, 1, hot_pc, 1'b1, 1'b1, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_HIST_UPDATE, 2, hot_pc, 1'b0, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_SQUASH, 3, '0, 1'b0, 1'b0, 1'b0, '1));
        op_queue.push_back(branch_op(gbp_pkg::OP_HIST_UPDATE, 3, '0, 1'b1, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_TRAIN, 0, hot_pc, 1'b0, 1'b0, 1'b1, '1));
        op_queue.push_back(branch_op(gbp_pkg::OP_SQUASH, 0, '0, 1'b0, 1'b0, 1'b0, '0));
        repeat (4)
            op_queue.push_back(branch_op(gbp_pkg::OP_TRAIN, 0, hot_pc, 1'b1, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_LOOKUP, 0, hot_pc, 1'b0, 1'b0, 1'b0, '0));
        repeat (4)
            op_queue.push_back(branch_op(gbp_pkg::OP_TRAIN, 0, hot_pc, 1'b0, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_LOOKUP, 0, hot_pc, 1'b0, 1'b0, 1'b0, '0));
        op_queue.push_back(branch_op(gbp_pkg::OP_TRAIN, 2, ones_pc, 1'b1, 1'b1, 1'b0, '1));
        queue_random_ops(120);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        shifts = '{2'd0, 2'd3, 2'd1};
        foreach (shifts[i])
        begin
            write_pc_shift(shifts[i]);
            queue_random_ops(125);
            wait_drained();
        end
        repeat (8) @(posedge clk);

        if (rsp_queue.size() != 0)
        begin
            $error("%0d responses never arrived", rsp_queue.size());
            mismatches++;
        end
        $display("Checked %0d responses: %0d lookups (%0d predicted taken), %0d updates,",
                 rsps_checked, op_count[gbp_pkg::OP_LOOKUP], taken_preds,
                 op_count[gbp_pkg::OP_HIST_UPDATE]);
        $display("%0d squashes, %0d trains, over pc_shift 2, 0, 3 and 1; %0d mismatches.",
                 op_count[gbp_pkg::OP_SQUASH], op_count[gbp_pkg::OP_TRAIN], mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
